// File: sv/tfdm_pkg.sv
// Shared types and constants for the three-frame difference motion mask.
// No dependencies; imported by tfdm_diff and the top level.
`default_nettype none

package tfdm_pkg;

  localparam int PIX_W  = 8;
  localparam int MAX_CH = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [1:0]       frame_cnt_t;

  localparam pix_t       THRESH_RESET = pix_t'(45);
  localparam frame_cnt_t FRAMES_FULL  = frame_cnt_t'(2);

endpackage

`default_nettype wire

// File: sv/tfdm_store.sv
// Frame store: one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module tfdm_store #(
  parameter int DEPTH  = 524288,
  parameter int ADDR_W = 19,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tfdm_diff.sv
// Per-channel double difference, threshold compare and store update word.
// Depends on tfdm_pkg.
`default_nettype none

module tfdm_diff
  import tfdm_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic [CHANNELS-1:0][PIX_W-1:0] pix,
  input  logic [2*CHANNELS*PIX_W-1:0]    entry,
  input  logic                           first,
  input  pix_t                           threshold,
  output logic                           motion,
  output logic [2*CHANNELS*PIX_W-1:0]    next_entry
);

  localparam int MID_BASE = CHANNELS * PIX_W;

  logic [CHANNELS-1:0] hit;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    pix_t oldest;
    pix_t mid;
    pix_t d_prev;
    pix_t d_cur;

    assign oldest = first ? pix[c] : entry[c*PIX_W +: PIX_W];
    assign mid    = first ? pix[c] : entry[MID_BASE + c*PIX_W +: PIX_W];
    assign d_prev = (mid > oldest) ? pix_t'(mid - oldest) : pix_t'(oldest - mid);
    assign d_cur  = (pix[c] > mid) ? pix_t'(pix[c] - mid) : pix_t'(mid - pix[c]);
    assign hit[c] = (d_prev & d_cur) > threshold;

    assign next_entry[c*PIX_W +: PIX_W]            = mid;
    assign next_entry[MID_BASE + c*PIX_W +: PIX_W] = pix[c];
  end

  assign motion = |hit;

endmodule

`default_nettype wire

// File: sv/three_frame_difference_motion_mask.sv
// out_valid is registered from s1_valid. Throughput: one pixel per cycle while
// out_ready is high, set by the store's one read and one write port (read at accept,
// read-modify-write in the second stage, forwarding between them).
// Reset clears the pipeline valids, pixel address and frame count and loads the
// threshold with 45; the frame store is not cleared and is written before read.
`default_nettype none

module three_frame_difference_motion_mask
  import tfdm_pkg::*;
#(
  parameter int MAX_PIXELS = 524288,
  parameter int CHANNELS   = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  pix_t cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t red,
  input  pix_t green,
  input  pix_t blue,
  input  logic frame_end,
  output logic out_valid,
  input  logic out_ready,
  output logic motion,
  output logic mask_frame_end
);

  localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int ENTRY_W = 2 * CHANNELS * PIX_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

  pix_t                          motion_threshold;
  logic [ADDR_W-1:0]             pixel_address;
  logic [ADDR_W-1:0]             pixel_address_next;
  frame_cnt_t                    frames_seen;

  logic                          s1_valid;
  logic [ADDR_W-1:0]             s1_addr;
  logic [CHANNELS-1:0][PIX_W-1:0] s1_pix;
  logic                          s1_first;
  logic                          s1_end;
  logic                          s1_fwd;
  logic [ENTRY_W-1:0]            s1_fwd_data;

  logic [MAX_CH-1:0][PIX_W-1:0]  pix_all;
  logic [CHANNELS-1:0][PIX_W-1:0] in_pix;
  logic                          in_accept;
  logic                          s1_advance;
  logic                          wr_en;
  logic [ENTRY_W-1:0]            rd_data;
  logic [ENTRY_W-1:0]            s1_entry;
  logic [ENTRY_W-1:0]            next_entry;
  logic                          diff_motion;

  assign pix_all = {pix_t'(0), blue, green, red};

  for (genvar c = 0; c < CHANNELS; c++) begin : g_pix
    assign in_pix[c] = pix_all[c];
  end

  assign cfg_ready  = 1'b1;
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;
  assign wr_en      = s1_valid && s1_advance;
  assign s1_entry   = s1_fwd ? s1_fwd_data : rd_data;

  always_comb begin
    if (frame_end || pixel_address == LAST_ADDR) begin
      pixel_address_next = '0;
    end else begin
      pixel_address_next = pixel_address + ADDR_W'(1);
    end
  end

  tfdm_store #(
    .DEPTH  (MAX_PIXELS),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (next_entry),
    .rd_en   (in_accept),
    .rd_addr (pixel_address),
    .rd_data (rd_data)
  );

  tfdm_diff #(
    .CHANNELS (CHANNELS)
  ) u_diff (
    .pix        (s1_pix),
    .entry      (s1_entry),
    .first      (s1_first),
    .threshold  (motion_threshold),
    .motion     (diff_motion),
    .next_entry (next_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold <= THRESH_RESET;
      pixel_address    <= '0;
      frames_seen      <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        motion_threshold <= cfg_data;
      end
      if (in_accept) begin
        pixel_address <= pixel_address_next;
        if (frame_end && frames_seen != FRAMES_FULL) begin
          frames_seen <= frames_seen + frame_cnt_t'(1);
        end
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr     <= pixel_address;
      s1_pix      <= in_pix;
      s1_first    <= (frames_seen == '0);
      s1_end      <= frame_end;
      s1_fwd      <= wr_en && (s1_addr == pixel_address);
      s1_fwd_data <= next_entry;
    end
    if (wr_en) begin
      motion         <= diff_motion;
      mask_frame_end <= s1_end;
    end
  end

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    pixel_address <= LAST_ADDR)
    else $error("pixel address beyond store depth");

  a_frames_sat: assert property (@(posedge clk) disable iff (rst)
    frames_seen <= FRAMES_FULL)
    else $error("frame count beyond saturation");

  a_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (in_accept && frame_end) |=> (pixel_address == '0))
    else $error("address not reset after frame end");

  a_fwd_hit: assert property (@(posedge clk) disable iff (rst)
    (in_accept && wr_en && s1_addr == pixel_address) |=> s1_fwd)
    else $error("same-address write not forwarded");

  a_first_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_first) |-> !diff_motion)
    else $error("motion flagged during first frame");

endmodule

`default_nettype wire
